### rtl/vtss_pkg.sv
// ----------------------------------------------------------------------------
// vtss_pkg
// Types and constants shared by the video timing sprite scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package vtss_pkg;

  // register indexes on the APB port (byte address is 4 * index)
  localparam logic [2:0] RegBackporch  = 3'd0;
  localparam logic [2:0] RegLine       = 3'd1;
  localparam logic [2:0] RegBlank      = 3'd2;
  localparam logic [2:0] RegLinesFrame = 3'd3;
  localparam logic [2:0] RegSprCount   = 3'd4;

  // reset values
  localparam logic [7:0] BackporchRst  = 8'd6;
  localparam logic [7:0] LineRst       = 8'd88;
  localparam logic [7:0] BlankRst      = 8'd198;
  localparam logic [8:0] LinesFrameRst = 9'd310;
  localparam logic [4:0] SprCountRst   = 5'd0;

  localparam logic CmdTick = 1'b0;
  localparam logic CmdLoad = 1'b1;

  typedef struct packed {
    logic [7:0] backporch_interval;
    logic [7:0] line_interval;
    logic [7:0] blank_interval;
    logic [8:0] lines_per_frame;
    logic [4:0] sprite_count;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [8:0]  start_line;
    logic [15:0] base_addr;
    logic [7:0]  row_width;
    logic [7:0]  row_count;
  } item_t;

  typedef struct packed {
    logic [8:0]  start_line;
    logic [15:0] base_addr;
    logic [7:0]  row_width;
    logic [7:0]  row_count;
  } entry_t;

  typedef struct packed {
    logic [7:0]  compare_value;
    logic        draw;
    logic [15:0] fetch_addr;
    logic        in_vblank;
  } res_t;

endpackage

`default_nettype wire

### rtl/vtss_ram.sv
// ----------------------------------------------------------------------------
// vtss_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vtss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                       wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/vtss_core.sv
// ----------------------------------------------------------------------------
// vtss_core
// Line sequencer state, sprite table and per-beat result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module vtss_core #(
  parameter int MaxEntries = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire vtss_pkg::item_t item_i,
  input  wire vtss_pkg::cfg_t  cfg_i,
  output vtss_pkg::res_t       res_o
);

  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int PW = $clog2(MaxEntries + 1);

  logic          wait_q, wait_d;
  logic          vblank_q, vblank_d;
  logic [8:0]    line_q, line_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [7:0]    row_q, row_d;

  logic                 we;
  logic [AW-1:0]        waddr;
  vtss_pkg::entry_t     wdata;
  vtss_pkg::entry_t     rdata;
  logic                 byp_q;
  vtss_pkg::entry_t     byp_data_q;
  vtss_pkg::entry_t     ent;

  logic [PW-1:0] active;
  logic [8:0]    line_dec;
  logic [7:0]    row_inc;
  logic [15:0]   prod;
  logic          hit;

  assign we    = fire_i && (item_i.cmd == vtss_pkg::CmdLoad)
                 && (32'(item_i.slot) < 32'(MaxEntries));
  assign waddr = AW'(item_i.slot);
  assign wdata = '{start_line: item_i.start_line, base_addr: item_i.base_addr,
                   row_width: item_i.row_width, row_count: item_i.row_count};

  // read ahead at the next pointer so the entry is ready for the next tick
  vtss_ram #(
    .Width ($bits(vtss_pkg::entry_t)),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_d[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we && (waddr == ptr_d[AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  assign ent = byp_q ? byp_data_q : rdata;

  always_comb begin
    if (32'(cfg_i.sprite_count) > 32'(MaxEntries)) begin
      active = PW'(MaxEntries);
    end else begin
      active = PW'(cfg_i.sprite_count);
    end
    line_dec = line_q - 9'd1;
    row_inc  = row_q + 8'd1;
    prod     = row_q * ent.row_width;
    hit      = (ptr_q < active) && (line_dec <= ent.start_line)
               && (row_q < ent.row_count);

    wait_d   = wait_q;
    vblank_d = vblank_q;
    line_d   = line_q;
    ptr_d    = ptr_q;
    row_d    = row_q;
    res_o    = '0;

    if (fire_i && (item_i.cmd == vtss_pkg::CmdTick)) begin
      if (wait_q) begin
        res_o.compare_value = vblank_q ? cfg_i.blank_interval : cfg_i.backporch_interval;
        wait_d = 1'b0;
      end else begin
        res_o.compare_value = cfg_i.line_interval;
        vblank_d = 1'b0;
        wait_d   = 1'b1;
        line_d   = line_dec;
        if (hit) begin
          res_o.draw       = 1'b1;
          res_o.fetch_addr = ent.base_addr + prod;
          if (row_inc == ent.row_count) begin
            ptr_d = ptr_q + PW'(1);
            row_d = 8'd0;
          end else begin
            row_d = row_inc;
          end
        end
        if (line_dec == 9'd0) begin
          line_d   = cfg_i.lines_per_frame;
          vblank_d = 1'b1;
          ptr_d    = '0;
        end
      end
    end
    res_o.in_vblank = vblank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q   <= 1'b0;
      vblank_q <= 1'b0;
      line_q   <= vtss_pkg::LinesFrameRst;
      ptr_q    <= '0;
      row_q    <= 8'd0;
    end else begin
      wait_q   <= wait_d;
      vblank_q <= vblank_d;
      line_q   <= line_d;
      ptr_q    <= ptr_d;
      row_q    <= row_d;
    end
  end

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) <= 32'(MaxEntries))
    else $error("sprite pointer beyond table");

  a_load_keeps_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.cmd == vtss_pkg::CmdLoad) |=> $stable(line_q) && $stable(ptr_q))
    else $error("load beat changed line state");

  a_sync_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.cmd == vtss_pkg::CmdTick) |=> (wait_q != $past(wait_q)))
    else $error("sync wait did not toggle on tick");

  a_draw_only_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.draw |-> !wait_q && fire_i)
    else $error("fetch outside a line tick");
`endif

endmodule

`default_nettype wire

### rtl/video_timing_sprite_scheduler_top.sv
// ----------------------------------------------------------------------------
// video_timing_sprite_scheduler_top
// Composite video line sequencer with sprite row fetch scheduling.
//
//  Channel   Dir  Handshake                 Content
//  s_axis    in   tvalid/tready             tdata: item fields, tuser: cmd
//  m_axis    out  tvalid/tready             tdata: result fields
//  APB       in   psel/penable/pwrite       five config registers at 4*i
//
//  One beat accepted per cycle; its result is registered and shown the
//  cycle after acceptance. The sprite entry for the current pointer is
//  read ahead from the table RAM, so a tick's result is formed in the cycle it is accepted.
//  Input stalls only while a result is held and m_axis_tready is low.
//  Reset is asynchronous; the sprite table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module video_timing_sprite_scheduler_top #(
  parameter int MaxEntries = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slot[3:0], start_line[12:4], base_addr[28:13], row_width[36:29],
  // row_count[44:37], zero [47:45]
  input  wire logic [47:0] s_axis_tdata,
  // cmd[0]
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // compare_value[7:0], draw[8], fetch_addr[24:9], in_vblank[25], zero [31:26]
  output logic      [31:0] m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  vtss_pkg::cfg_t  cfg_q;
  vtss_pkg::item_t item;
  vtss_pkg::res_t  res;
  vtss_pkg::res_t  out_q;
  logic            out_valid_q;
  logic            fire;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backporch_interval <= vtss_pkg::BackporchRst;
      cfg_q.line_interval      <= vtss_pkg::LineRst;
      cfg_q.blank_interval     <= vtss_pkg::BlankRst;
      cfg_q.lines_per_frame    <= vtss_pkg::LinesFrameRst;
      cfg_q.sprite_count       <= vtss_pkg::SprCountRst;
    end else if (cfg_we) begin
      case (paddr[4:2])
        vtss_pkg::RegBackporch:  cfg_q.backporch_interval <= pwdata[7:0];
        vtss_pkg::RegLine:       cfg_q.line_interval      <= pwdata[7:0];
        vtss_pkg::RegBlank:      cfg_q.blank_interval     <= pwdata[7:0];
        vtss_pkg::RegLinesFrame: cfg_q.lines_per_frame    <= pwdata[8:0];
        vtss_pkg::RegSprCount:   cfg_q.sprite_count       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      vtss_pkg::RegBackporch:  prdata = {24'd0, cfg_q.backporch_interval};
      vtss_pkg::RegLine:       prdata = {24'd0, cfg_q.line_interval};
      vtss_pkg::RegBlank:      prdata = {24'd0, cfg_q.blank_interval};
      vtss_pkg::RegLinesFrame: prdata = {23'd0, cfg_q.lines_per_frame};
      vtss_pkg::RegSprCount:   prdata = {27'd0, cfg_q.sprite_count};
      default:                 prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  assign item.cmd        = s_axis_tuser[0];
  assign item.slot       = s_axis_tdata[3:0];
  assign item.start_line = s_axis_tdata[12:4];
  assign item.base_addr  = s_axis_tdata[28:13];
  assign item.row_width  = s_axis_tdata[36:29];
  assign item.row_count  = s_axis_tdata[44:37];

  vtss_core #(
    .MaxEntries (MaxEntries)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.in_vblank, out_q.fetch_addr, out_q.draw,
                          out_q.compare_value};

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_beat_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(out_q) && !$past(fire))
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

### test/vtss_sched_checker.sv
// ----------------------------------------------------------------------------
// vtss_sched_checker
// Watches the item, result and APB channels of the sprite scheduler, keeps
// its own line sequencer and sprite schedule in step with accepted beats and
// register writes, and compares every result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vtss_sched_checker #(
  parameter int MaxEntries = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slot[3:0], start_line[12:4], base_addr[28:13], row_width[36:29],
  // row_count[44:37], zero [47:45]
  input  wire logic [47:0] s_tdata_i,
  // cmd[0]
  input  wire logic [0:0]  s_tuser_i,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  // compare_value[7:0], draw[8], fetch_addr[24:9], in_vblank[25], zero [31:26]
  input  wire logic [31:0] m_tdata_i,
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  input  wire logic        pready_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               ticks_o,
  output int               loads_o,
  output int               draws_o,
  output int               wraps_o
);

  localparam int AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  vtss_pkg::cfg_t   timing;
  logic             sync_wait;
  logic             vblank;
  logic [8:0]       line_ctr;
  logic [4:0]       spr_ptr;
  logic [7:0]       spr_row;
  vtss_pkg::entry_t spr_tab [MaxEntries];
  vtss_pkg::res_t   due_results [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic vtss_pkg::res_t next_line_result(input vtss_pkg::item_t beat);
    vtss_pkg::res_t   r;
    vtss_pkg::entry_t e;
    int               live;
    r = '0;
    if (beat.cmd == vtss_pkg::CmdLoad) begin
      loads_o++;
      if (int'(beat.slot) < MaxEntries) begin
        spr_tab[AW'(beat.slot)] = '{start_line: beat.start_line, base_addr: beat.base_addr,
                                    row_width: beat.row_width, row_count: beat.row_count};
      end
    end else if (sync_wait) begin
      ticks_o++;
      r.compare_value = vblank ? timing.blank_interval : timing.backporch_interval;
      sync_wait = 1'b0;
    end else begin
      ticks_o++;
      r.compare_value = timing.line_interval;
      vblank = 1'b0;
      sync_wait = 1'b1;
      line_ctr = line_ctr - 9'd1;
      live = (int'(timing.sprite_count) > MaxEntries) ? MaxEntries : int'(timing.sprite_count);
      if (int'(spr_ptr) < live) begin
        e = spr_tab[AW'(spr_ptr)];
        if (line_ctr <= e.start_line && spr_row < e.row_count) begin
          r.draw = 1'b1;
          r.fetch_addr = e.base_addr + 16'(spr_row) * 16'(e.row_width);
          draws_o++;
          spr_row = spr_row + 8'd1;
          if (spr_row == e.row_count) begin
            spr_ptr = spr_ptr + 5'd1;
            spr_row = '0;
          end
        end
      end
      if (line_ctr == '0) begin
        line_ctr = timing.lines_per_frame;
        vblank = 1'b1;
        spr_ptr = '0;
        wraps_o++;
      end
    end
    r.in_vblank = vblank;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vtss_pkg::item_t beat;
    vtss_pkg::res_t  due;
    if (!rst_ni) begin
      timing = '{backporch_interval: vtss_pkg::BackporchRst,
                 line_interval: vtss_pkg::LineRst,
                 blank_interval: vtss_pkg::BlankRst,
                 lines_per_frame: vtss_pkg::LinesFrameRst,
                 sprite_count: vtss_pkg::SprCountRst};
      sync_wait = 1'b0;
      vblank = 1'b0;
      line_ctr = vtss_pkg::LinesFrameRst;
      spr_ptr = '0;
      spr_row = '0;
      for (int i = 0; i < MaxEntries; i++) spr_tab[i] = '0;
      due_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      ticks_o = 0;
      loads_o = 0;
      draws_o = 0;
      wraps_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          vtss_pkg::RegBackporch:  timing.backporch_interval = pwdata_i[7:0];
          vtss_pkg::RegLine:       timing.line_interval = pwdata_i[7:0];
          vtss_pkg::RegBlank:      timing.blank_interval = pwdata_i[7:0];
          vtss_pkg::RegLinesFrame: timing.lines_per_frame = pwdata_i[8:0];
          vtss_pkg::RegSprCount:   timing.sprite_count = pwdata_i[4:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with none pending", int'(m_tdata_i), 0);
        end else begin
          due = due_results.pop_front();
          if (m_tdata_i[7:0] != due.compare_value)
            report_mismatch("compare_value", int'(m_tdata_i[7:0]), int'(due.compare_value));
          if (m_tdata_i[8] != due.draw)
            report_mismatch("draw", int'(m_tdata_i[8]), int'(due.draw));
          if (m_tdata_i[24:9] != due.fetch_addr)
            report_mismatch("fetch_addr", int'(m_tdata_i[24:9]), int'(due.fetch_addr));
          if (m_tdata_i[25] != due.in_vblank)
            report_mismatch("in_vblank", int'(m_tdata_i[25]), int'(due.in_vblank));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        beat.cmd = s_tuser_i[0];
        beat.slot = s_tdata_i[3:0];
        beat.start_line = s_tdata_i[12:4];
        beat.base_addr = s_tdata_i[28:13];
        beat.row_width = s_tdata_i[36:29];
        beat.row_count = s_tdata_i[44:37];
        due_results.push_back(next_line_result(beat));
      end
      pending_o = due_results.size();
    end
  end

endmodule

### test/tb_video_timing_sprite_scheduler_top.sv
// ----------------------------------------------------------------------------
// tb_video_timing_sprite_scheduler_top
// Drives sprite table loads and timer ticks through several timing setups
// (extreme intervals, one-line and zero-line frames, oversized sprite count),
// with bursty input, a patterned and a long-held output ready, and leaves
// the checking to vtss_sched_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_video_timing_sprite_scheduler_top;

  localparam int TableDepth = 16;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   pending;
  int   ticks_seen;
  int   loads_seen;
  int   draws_seen;
  int   wraps_seen;
  int   burst_left = 4;
  int   reg_writes = 0;
  int   quiet = 0;
  logic hold_req = 1'b0;

  video_timing_sprite_scheduler_top #(
    .MaxEntries(TableDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  vtss_sched_checker #(
    .MaxEntries(TableDepth)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .ticks_o     (ticks_seen),
    .loads_o     (loads_seen),
    .draws_o     (draws_seen),
    .wraps_o     (wraps_seen)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $display("[%0t] no beat for %0d cycles", $time, QuietLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // output side: rotating ready patterns, plus one long hold-off on request
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((cyc % 8) < 5);
        endcase
      end
    end
  end

  function automatic vtss_pkg::item_t random_fields();
    vtss_pkg::item_t b;
    b.cmd = vtss_pkg::CmdTick;
    b.slot = 4'($urandom);
    b.start_line = 9'($urandom);
    b.base_addr = 16'($urandom);
    b.row_width = 8'($urandom);
    b.row_count = 8'($urandom);
    return b;
  endfunction

  task automatic push_beat(input vtss_pkg::item_t b);
    logic rdy;
    s_axis_tdata <= {3'b000, b.row_count, b.row_width, b.base_addr, b.start_line, b.slot};
    s_axis_tuser <= b.cmd;
    s_axis_tvalid <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 12));
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input int bp, input int ln, input int bl, input int lpf,
                            input int cnt);
    settle();
    apb_write(vtss_pkg::RegBackporch, bp);
    apb_write(vtss_pkg::RegLine, ln);
    apb_write(vtss_pkg::RegBlank, bl);
    apb_write(vtss_pkg::RegLinesFrame, lpf);
    apb_write(vtss_pkg::RegSprCount, cnt);
  endtask

  // fills every slot, start lines descending from top
  task automatic load_table(input int top, input int zero_slot);
    int              start;
    vtss_pkg::item_t b;
    for (int i = 0; i < TableDepth; i++) begin
      start = top - (i * (top + 1)) / TableDepth - $urandom_range(0, (top + 1) / 40);
      if (start < 0) start = 0;
      b = random_fields();
      b.cmd = vtss_pkg::CmdLoad;
      b.slot = 4'(i);
      b.start_line = 9'(start);
      b.row_count = (i == zero_slot) ? 8'd0 : 8'($urandom_range(1, 6));
      push_beat(b);
    end
  endtask

  task automatic run_lines(input int n_ticks, input int top);
    int              ticks;
    vtss_pkg::item_t b;
    ticks = 0;
    while (ticks < n_ticks) begin
      b = random_fields();
      if ($urandom_range(0, 15) == 0) begin
        b.cmd = vtss_pkg::CmdLoad;
        if ($urandom_range(0, 3) != 0) b.start_line = 9'($urandom_range(0, top));
        if ($urandom_range(0, 2) != 0) b.row_count = 8'($urandom_range(0, 6));
      end else begin
        ticks++;
      end
      push_beat(b);
    end
  endtask

  initial begin
    vtss_pkg::item_t b;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: full table, extreme entries, a wrapping fetch address
    load_table(300, TableDepth);
    b = random_fields();
    b.cmd = vtss_pkg::CmdLoad;
    b.slot = 4'd0;
    b.start_line = 9'h1FF;
    b.base_addr = 16'hFFFF;
    b.row_width = 8'hFF;
    b.row_count = 8'd3;
    push_beat(b);
    b.slot = 4'd15;
    b.start_line = '0;
    b.base_addr = '0;
    b.row_width = '0;
    b.row_count = 8'hFF;
    push_beat(b);
    set_timing(int'(vtss_pkg::BackporchRst), int'(vtss_pkg::LineRst),
               int'(vtss_pkg::BlankRst), int'(vtss_pkg::LinesFrameRst), 1);
    repeat (7) push_beat(random_fields());

    // long first frame, then short frames; output held off early on
    set_timing(0, 255, 255, 12, 16);
    load_table(300, TableDepth);
    hold_req = 1'b1;
    run_lines(620, 300);

    // one-line frame, count beyond the table
    set_timing(255, 0, 0, 1, 31);
    run_lines(30, 1);

    // entry with no rows blocks the rest of the frame
    set_timing($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 20, 5);
    load_table(20, 2);
    run_lines(60, 20);

    // zero reload value, counter wraps to the top
    set_timing($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 0, 16);
    run_lines(30, 20);

    settle();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d ticks and %0d table loads: %0d sprite rows fetched, %0d frame wraps",
             ticks_seen, loads_seen, draws_seen, wraps_seen);
    $display("%0d register writes over five timing setups, one %0d-cycle output hold-off",
             reg_writes, HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
